### rtl/bdc_pkg.sv
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared types and constants for the De Casteljau Bezier evaluator.
// ----------------------------------------------------------------------------
package bdc_pkg;

    localparam int VAL_W   = 32;
    localparam int T_W     = 17;
    localparam int IDX_W   = 4;
    localparam int CNT_CFG_W = 5;

    localparam logic [T_W-1:0]       T_ONE        = 17'h10000;
    localparam logic [CNT_CFG_W-1:0] PC_RESET     = 5'd2;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_EVAL  = 1'b1
    } kind_t;

    typedef struct packed {
        logic             load;
        logic             step;
        logic [T_W-1:0]   t;
    } cell_ctrl_t;

endpackage

### rtl/bdc_cell.sv
// ----------------------------------------------------------------------------
// bdc_cell
// One slot of the lerp row: holds a control point and a working value, and
// interpolates toward its right-hand neighbor once per level.
// ----------------------------------------------------------------------------
module bdc_cell
    import bdc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cell_ctrl_t         ctrl,
    input  logic               wr_en,
    input  logic [VAL_W-1:0]   wr_data,
    input  logic [VAL_W-1:0]   next_row,
    output logic [VAL_W-1:0]   row
);

    logic [VAL_W-1:0]   point_reg;
    logic [VAL_W-1:0]   row_reg;
    logic [VAL_W-1:0]   row_next;
    logic signed [VAL_W:0]       diff;
    logic signed [VAL_W+T_W+1:0] prod;
    logic signed [VAL_W+T_W+1:0] delta;

    assign diff  = $signed({next_row[VAL_W-1], next_row}) - $signed({row_reg[VAL_W-1], row_reg});
    assign prod  = diff * $signed({1'b0, ctrl.t});
    assign delta = prod >>> 16;

    always_comb begin
        row_next = row_reg;
        if (ctrl.load) begin
            row_next = point_reg;
        end else if (ctrl.step) begin
            row_next = row_reg + delta[VAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_reg <= '0;
        end else if (wr_en) begin
            point_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg <= row_next;
    end

    assign row = row_reg;

endmodule

### rtl/bezier_de_casteljau_eval.sv
// ----------------------------------------------------------------------------
// bezier_de_casteljau_eval
// 1-D Bezier curve evaluation by De Casteljau lerp levels over a cell row.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  s_      | in  | s_tvalid/s_tready   | tuser: kind; tdata: index, value, t
//  m_      | out | m_tvalid/m_tready   | tdata: curve_value
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_data: point_count
//
//  Write word: accepted and stored in its cell.
//  Evaluate word: row load, lerp levels over n points, output write;
//  n = point_count clamped to 1..MAX_POINTS; one level per cycle in the row.
//  s_tready is low while an evaluation runs; a full output register holds
//  the last level until m_tready. Reset clears the point store, point_count=2.
// ----------------------------------------------------------------------------
module bezier_de_casteljau_eval
    import bdc_pkg::*;
#(
    parameter int MAX_POINTS = 16
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [55:0]          s_tdata,   // point_index[3:0], point_value[35:4], t_param[52:36]
    input  logic                 s_tuser,   // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [VAL_W-1:0]     m_tdata,   // curve_value
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CNT_CFG_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_POINTS);

    logic [IDX_W-1:0]     in_idx;
    logic [VAL_W-1:0]     in_val;
    logic [T_W-1:0]       in_t;
    logic                 s_acc;
    logic                 eval_acc;
    logic                 wr_acc;

    logic [CNT_CFG_W-1:0] pc_reg;
    logic                 busy_reg;
    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        levels;
    logic [T_W-1:0]       t_reg;
    logic                 m_tvalid_reg;
    logic [VAL_W-1:0]     m_tdata_reg;
    logic                 finish;
    cell_ctrl_t           ctrl;

    logic [VAL_W-1:0]     rows [MAX_POINTS];

    assign in_idx   = s_tdata[3:0];
    assign in_val   = s_tdata[35:4];
    assign in_t     = s_tdata[52:36];
    assign s_tready = !busy_reg;
    assign cfg_ready = 1'b1;
    assign s_acc    = s_tvalid && s_tready;
    assign eval_acc = s_acc && (kind_t'(s_tuser) == KIND_EVAL);
    assign wr_acc   = s_acc && (kind_t'(s_tuser) == KIND_WRITE);
    assign finish   = busy_reg && (cnt_reg == '0) && (!m_tvalid_reg || m_tready);

    always_comb begin
        if (pc_reg == '0) begin
            levels = '0;
        end else if (32'(pc_reg) > MAX_POINTS) begin
            levels = CW'(MAX_POINTS - 1);
        end else begin
            levels = CW'(32'(pc_reg) - 32'd1);
        end
    end

    assign ctrl.load = eval_acc;
    assign ctrl.step = busy_reg && (cnt_reg != '0);
    assign ctrl.t    = t_reg;

    genvar g;
    generate
        for (g = 0; g < MAX_POINTS; g++) begin : g_cell
            logic [VAL_W-1:0] nb;
            if (g == MAX_POINTS - 1) begin : g_last
                assign nb = rows[g];
            end else begin : g_mid
                assign nb = rows[g+1];
            end
            bdc_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl),
                .wr_en    (wr_acc && (32'(in_idx) == g)),
                .wr_data  (in_val),
                .next_row (nb),
                .row      (rows[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= PC_RESET;
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                pc_reg <= cfg_data;
            end
            if (eval_acc) begin
                busy_reg <= 1'b1;
                cnt_reg  <= levels;
            end else if (ctrl.step) begin
                cnt_reg <= cnt_reg - CW'(1);
            end else if (finish) begin
                busy_reg <= 1'b0;
            end
            if (finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (eval_acc) begin
            t_reg <= (in_t > T_ONE) ? T_ONE : in_t;
        end
        if (finish) begin
            m_tdata_reg <= rows[0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_tready)
        else $error("input accepted during evaluation");

    a_eval_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        eval_acc |=> busy_reg && (cnt_reg == $past(levels)))
        else $error("evaluation did not start with level count");

    a_finish_out: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> m_tvalid_reg && !busy_reg)
        else $error("finished evaluation not presented");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (32'(cnt_reg) < MAX_POINTS))
        else $error("level count out of range");

endmodule

### tb/sv/tb_bezier_de_casteljau_eval.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bezier_de_casteljau_eval
// Self-checking bench for the De Casteljau Bezier evaluator. Control point
// writes and curve evaluations are streamed in under random gaps and output
// stalls, including one long output hold-off. Each phase sets its own point
// count, and the extremes are among them. A scoreboard keeps its own point
// store and computes every curve value by repeated floor-rounded lerp.
// ----------------------------------------------------------------------------
module tb_bezier_de_casteljau_eval;
    import bdc_pkg::*;

    localparam int MAX_PTS        = 16;
    localparam int SETTLE_CYCLES  = MAX_PTS + 4;
    localparam int HOLD_CYCLES    = 400;
    localparam int ITEMS_PER_STEP = 100;

    class curve_scoreboard;
        logic [VAL_W-1:0]     points [MAX_PTS] = '{default: '0};
        logic [CNT_CFG_W-1:0] point_count      = PC_RESET;
        logic [VAL_W-1:0]     curve_q [$];
        int unsigned          errors           = 0;

        function void set_count(logic [CNT_CFG_W-1:0] value);
            point_count = value;
        endfunction

        function logic [VAL_W-1:0] curve_at(logic [T_W-1:0] t_raw);
            longint row [MAX_PTS];
            longint tq;
            int     n;
            tq = (t_raw > T_ONE) ? longint'(T_ONE) : longint'(t_raw);
            n  = point_count;
            if (n < 1) n = 1;
            if (n > MAX_PTS) n = MAX_PTS;
            for (int i = 0; i < n; i++) row[i] = longint'($signed(points[i]));
            for (int lvl = 1; lvl < n; lvl++)
                for (int i = 0; i + lvl < n; i++)
                    row[i] = row[i] + ((tq * (row[i+1] - row[i])) >>> 16);
            return row[0][VAL_W-1:0];
        endfunction

        function void note_word(kind_t kind, logic [IDX_W-1:0] idx,
                                logic [VAL_W-1:0] value, logic [T_W-1:0] t);
            if (kind == KIND_WRITE) begin
                if (idx < MAX_PTS) points[idx] = value;
            end else begin
                curve_q.push_back(curve_at(t));
            end
        endfunction

        function void check_word(logic [VAL_W-1:0] got);
            logic [VAL_W-1:0] want;
            if (curve_q.size() == 0) begin
                $error("curve_value: expected none, got %0d", $signed(got));
                errors++;
                return;
            end
            want = curve_q.pop_front();
            if (got !== want) begin
                $error("curve_value: expected %0d, got %0d", $signed(want), $signed(got));
                errors++;
            end
        endfunction

        function int unsigned pending();
            return curve_q.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [55:0]          s_tdata;   // point_index[3:0], point_value[35:4], t_param[52:36]
    logic                 s_tuser;   // kind
    logic                 m_tvalid;
    logic                 m_tready;
    logic [VAL_W-1:0]     m_tdata;   // curve_value
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CNT_CFG_W-1:0] cfg_data;

    curve_scoreboard sb = new;
    bit              no_idle   = 1'b0;
    bit              sink_hold = 1'b0;

    bezier_de_casteljau_eval #(.MAX_POINTS(MAX_PTS)) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("** bezier_de_casteljau_eval: FAILED **");
        $finish;
    end

    // monitors
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_word(kind_t'(s_tuser), s_tdata[3:0], s_tdata[35:4], s_tdata[52:36]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_word(m_tdata);
        if (aresetn && cfg_valid && cfg_ready)
            sb.set_count(cfg_data);
    end

    // output sink: random stalls, plus one long hold-off on request
    initial begin
        int unsigned span;
        int unsigned r;
        m_tready <= 1'b0;
        wait (aresetn);
        forever begin
            if (sink_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                sink_hold = 1'b0;
            end else if (no_idle) begin
                m_tready <= 1'b1;
                @(negedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    m_tready <= 1'b1;
                    span = $urandom_range(1, 8);
                end else if (r < 90) begin
                    m_tready <= 1'b0;
                    span = $urandom_range(1, 3);
                end else begin
                    m_tready <= 1'b0;
                    span = $urandom_range(10, 60);
                end
                repeat (span) @(negedge aclk);
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(kind_t kind, logic [IDX_W-1:0] idx,
                             logic [VAL_W-1:0] value, logic [T_W-1:0] t);
        int unsigned gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, t, value, idx};
        do @(posedge aclk); while (!s_tready);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic write_point(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] value);
        send_word(KIND_WRITE, idx, value, T_W'($urandom));
    endtask

    task automatic eval_curve(logic [T_W-1:0] t);
        send_word(KIND_EVAL, IDX_W'($urandom), VAL_W'($urandom), t);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_count(logic [CNT_CFG_W-1:0] value);
        drain();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [VAL_W-1:0] pick_point();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 4))
                0: return 32'h7fff_ffff;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                3: return 32'hffff_ffff;
                default: return 32'h0001_0000;
            endcase
        end
        if (r < 40) return VAL_W'($signed($urandom_range(0, 2 << 20)) - (1 << 20));
        return $urandom;
    endfunction

    function automatic logic [T_W-1:0] pick_t();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return T_ONE;
        if (r < 30) return T_W'($urandom_range(32'h10001, 32'h1ffff));
        return T_W'($urandom_range(0, 32'h10000));
    endfunction

    task automatic random_words(int unsigned count);
        for (int unsigned k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 45)
                write_point(IDX_W'($urandom_range(0, 15)), pick_point());
            else
                eval_curve(pick_t());
        end
    endtask

    initial begin
        logic [CNT_CFG_W-1:0] counts [10] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17,
                                              5'd2, 5'd5, 5'd8, 5'd16, 5'd3};
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= KIND_WRITE;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // directed, reset point count of two
        eval_curve(17'h08000);
        write_point(4'd0, 32'h7fff_ffff);
        write_point(4'd1, 32'h8000_0000);
        eval_curve(17'h00000);
        eval_curve(T_ONE);
        eval_curve(17'h1ffff);
        eval_curve(17'h08000);
        eval_curve(17'h00001);
        send_word(KIND_EVAL, 4'hf, 32'hffff_ffff, 17'h0ffff);
        send_word(KIND_WRITE, 4'hf, 32'h1234_5678, 17'h1ffff);
        write_point(4'd1, 32'hffff_0000);
        eval_curve(17'h0c000);
        write_point(4'd2, 32'h0003_0000);

        // single point, then the far slot comes into use
        write_count(5'd1);
        eval_curve(17'h1ffff);
        eval_curve(17'h05555);
        write_count(5'd16);
        eval_curve(17'h08000);
        eval_curve(T_ONE);

        for (int p = 0; p < 10; p++) begin
            write_count(counts[p]);
            no_idle   = (p == 5);
            sink_hold = (p == 8);
            random_words(ITEMS_PER_STEP);
        end
        no_idle = 1'b0;
        drain();

        if (sb.errors == 0)
            $display("** bezier_de_casteljau_eval: PASSED **");
        else
            $display("** bezier_de_casteljau_eval: FAILED **");
        $finish;
    end

endmodule

### files.f
rtl/bdc_pkg.sv
rtl/bdc_cell.sv
rtl/bezier_de_casteljau_eval.sv
tb/sv/tb_bezier_de_casteljau_eval.sv
